// ===== rtl/lst_pkg.sv =====
// Shared types and constants for the recency-ordered slot table.
package lst_pkg;

  localparam int SLOTS  = 8;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int STEP_W = ((IDX_W > 5) ? IDX_W : 5) + 2;
  localparam int TAG_W  = 32;

  localparam logic [1:0] MODE_OPEN  = 2'd0;
  localparam logic [1:0] MODE_REL   = 2'd1;
  localparam logic [1:0] MODE_ABS   = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [1:0] CFG_CYCLE_ENABLE = 2'd0;
  localparam logic [1:0] CFG_CYCLE_LENGTH = 2'd1;
  localparam logic [1:0] CFG_AUTO_REWIND  = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0] slot;
    logic [TAG_W-1:0] tag;
    logic             valid;
  } entry_t;

  typedef struct packed {
    logic             shift;
    logic             clear;
    logic [IDX_W-1:0] upto;
    entry_t           front;
    logic [TAG_W-1:0] key;
  } cell_cmd_t;

  typedef struct packed {
    logic       cycle_enable;
    logic [3:0] cycle_length;
    logic       auto_rewind;
  } cfg_t;

endpackage

// ===== rtl/lst_cell.sv =====
// One list position: slot number, key tag and valid bit, with its own tag compare.
module lst_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [lst_pkg::IDX_W-1:0] init_slot,
  input  logic [lst_pkg::TAG_W-1:0] key,
  input  logic                     clear,
  input  logic                     load,
  input  lst_pkg::entry_t          load_entry,
  output lst_pkg::entry_t          entry,
  output logic                     match
);

  logic [lst_pkg::IDX_W-1:0] slot;
  logic [lst_pkg::TAG_W-1:0] tag;
  logic                      valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= init_slot;
      valid <= 1'b0;
    end else if (clear) begin
      valid <= 1'b0;
    end else if (load) begin
      slot  <= load_entry.slot;
      valid <= load_entry.valid;
    end
  end

  // The tag only matters while the entry is valid.
  always_ff @(posedge clk) begin
    if (load) begin
      tag <= load_entry.tag;
    end
  end

  assign entry = '{slot: slot, tag: tag, valid: valid};
  assign match = valid && (tag == key);

endmodule

// ===== rtl/lst_ctrl.sv =====
// Sequencer: decodes a request, drives the cell row and builds the result item.
module lst_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  lst_pkg::cfg_t                      cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         mode,
  input  logic [lst_pkg::TAG_W-1:0]          key,
  input  logic                               open_ok,
  input  logic signed [4:0]                  delta,
  input  logic [3:0]                         position,
  input  lst_pkg::entry_t [lst_pkg::SLOTS-1:0] entries,
  input  logic [lst_pkg::SLOTS-1:0]          match,
  output lst_pkg::cell_cmd_t                 cmd,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               res_success,
  output logic [3:0]                         res_pos,
  output logic [3:0]                         res_slot,
  output logic                               res_hit,
  output logic                               res_rewind
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;

  localparam int IW = lst_pkg::IDX_W;
  localparam int SW = lst_pkg::STEP_W;
  localparam logic signed [IW:0]   NONE    = '1;
  localparam logic signed [SW-1:0] SLOTS_S = SW'(lst_pkg::SLOTS);
  localparam logic [IW-1:0]        LAST    = IW'(lst_pkg::SLOTS - 1);

  logic [1:0] state;

  logic [1:0]                mode_q;
  logic [lst_pkg::TAG_W-1:0] key_q;
  logic                      open_ok_q;
  logic signed [4:0]         delta_q;
  logic [3:0]                position_q;
  logic signed [SW-1:0]      pos_q;
  logic [IW-1:0]             tries_q;

  logic signed [IW:0] cur_pos;
  logic signed [IW:0] cur_slot;
  logic signed [IW:0] cur_pos_next;
  logic signed [IW:0] cur_slot_next;

  logic                 out_free;
  logic                 done;
  logic                 succ;
  logic                 hit;
  logic                 any_match;
  logic [IW-1:0]        found;
  logic signed [SW-1:0] len_s;
  logic signed [SW-1:0] upper;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] wrapped;
  logic [IW-1:0]        step_idx;
  logic                 step_valid;
  logic                 last_try;
  logic [IW-1:0]        abs_idx;
  logic signed [SW-1:0] pos_ext;
  logic signed [SW-1:0] slot_ext;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // First valid match from the front of the list.
  always_comb begin
    found = '0;
    for (int i = lst_pkg::SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        found = IW'(i);
      end
    end
  end
  assign any_match = |match;

  // Upper end of the cycling range, with the length clamped to 1..SLOTS, or the last position when cycling is off.
  always_comb begin
    len_s = $signed(SW'(cfg.cycle_length));
    if (len_s < 1) begin
      len_s = SW'(1);
    end else if (len_s > SLOTS_S) begin
      len_s = SLOTS_S;
    end
    upper = cfg.cycle_enable ? (len_s - SW'(1)) : (SLOTS_S - SW'(1));
  end

  // One relative step with wrap to the other end.
  always_comb begin
    sum = pos_q + SW'(delta_q);
    if (sum < 0) begin
      wrapped = upper;
    end else if (sum > upper) begin
      wrapped = '0;
    end else begin
      wrapped = sum;
    end
  end
  assign step_idx   = wrapped[IW-1:0];
  assign step_valid = entries[step_idx].valid;
  assign last_try   = (tries_q == LAST);
  assign abs_idx    = IW'(position_q);

  always_comb begin
    done          = 1'b0;
    succ          = 1'b0;
    hit           = 1'b0;
    cur_pos_next  = cur_pos;
    cur_slot_next = cur_slot;
    cmd           = '0;
    cmd.key       = key_q;
    case (state)
      ST_EXEC: begin
        if (mode_q == lst_pkg::MODE_OPEN) begin
          done = out_free;
          if (any_match) begin
            succ          = 1'b1;
            hit           = 1'b1;
            cmd.shift     = done;
            cmd.upto      = found;
            cmd.front     = entries[found];
            cur_pos_next  = '0;
            cur_slot_next = {1'b0, entries[found].slot};
          end else if (open_ok_q) begin
            // Miss: the least recently used slot takes the key.
            succ          = 1'b1;
            cmd.shift     = done;
            cmd.upto      = LAST;
            cmd.front     = '{slot: entries[lst_pkg::SLOTS-1].slot, tag: key_q, valid: 1'b1};
            cur_pos_next  = '0;
            cur_slot_next = {1'b0, entries[lst_pkg::SLOTS-1].slot};
          end
        end else if (mode_q == lst_pkg::MODE_ABS) begin
          done = out_free;
          if ({28'd0, position_q} < 32'(lst_pkg::SLOTS)) begin
            if (entries[abs_idx].valid) begin
              succ          = 1'b1;
              cur_pos_next  = {1'b0, abs_idx};
              cur_slot_next = {1'b0, entries[abs_idx].slot};
            end
          end else begin
            cur_pos_next  = NONE;
            cur_slot_next = NONE;
          end
        end else if (mode_q == lst_pkg::MODE_CLEAR) begin
          done          = out_free;
          cmd.clear     = done;
          cur_pos_next  = NONE;
          cur_slot_next = NONE;
        end
      end
      ST_STEP: begin
        if (step_valid) begin
          done          = out_free;
          succ          = 1'b1;
          cur_pos_next  = {1'b0, step_idx};
          cur_slot_next = {1'b0, entries[step_idx].slot};
        end else if (last_try) begin
          done = out_free;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cur_pos   <= NONE;
      cur_slot  <= NONE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (mode_q == lst_pkg::MODE_REL) begin
            state <= ST_STEP;
          end else if (done) begin
            state <= ST_IDLE;
          end
        end
        ST_STEP: begin
          if (done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (done) begin
        out_valid <= 1'b1;
        cur_pos   <= cur_pos_next;
        cur_slot  <= cur_slot_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign pos_ext  = SW'(cur_pos_next);
  assign slot_ext = SW'(cur_slot_next);

  // Request fields, step position and result fields.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      mode_q     <= mode;
      key_q      <= key;
      open_ok_q  <= open_ok;
      delta_q    <= delta;
      position_q <= position;
    end
    if (state == ST_EXEC) begin
      pos_q   <= SW'(cur_pos);
      tries_q <= '0;
    end else if (state == ST_STEP && !step_valid && !last_try) begin
      pos_q   <= wrapped;
      tries_q <= tries_q + IW'(1);
    end
    if (done) begin
      res_success <= succ;
      res_hit     <= hit;
      res_rewind  <= succ && cfg.auto_rewind;
      res_pos     <= pos_ext[3:0];
      res_slot    <= slot_ext[3:0];
    end
  end

  a_shift_only_open: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> (state == ST_EXEC && mode_q == lst_pkg::MODE_OPEN))
    else $error("cell row shifted outside an open");

  a_cur_pair: assert property (@(posedge clk) disable iff (rst)
    (cur_pos == NONE) == (cur_slot == NONE))
    else $error("current position and slot disagree on none");

  a_step_rel: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |-> (mode_q == lst_pkg::MODE_REL))
    else $error("stepping without a relative select");

  a_success_sel: assert property (@(posedge clk) disable iff (rst)
    (done && succ) |=> (cur_slot != NONE && cur_pos != NONE))
    else $error("successful item left no current slot");

  a_hit_success: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_hit) |-> res_success)
    else $error("hit reported without success");

endmodule

// ===== rtl/lru_slot_table_with_selection_core.sv =====
// Top level of the recency-ordered slot table: ports, configuration and the cell row.
//
//   channel   direction  handshake            contents
//   s_*       in         s_tvalid/s_tready    one request item
//   m_*       out        m_tvalid/m_tready    one result item per request
//   cfg_*     in         cfg_valid/cfg_ready  register index and write data
//
// An open, an absolute select or a clear-all is accepted in the idle state and
// finished in the execute state, in which the cells compare their tags with the key
// and, on an open that succeeds, shift one place toward the back in one step.
// A relative select goes on to the step state, where the single step adder of the
// sequencer tries one position at a time, up to SLOTS positions.
// Reset is synchronous; afterwards position i holds slot i and no slot is valid.
// A finished result waits in the output register while the next item is taken;
// the sequencer only stalls when it must write a result and that register is full.
module lru_slot_table_with_selection_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // key[31:0], open_ok[32], delta[37:33], position[41:38]
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // success[0], current_position[4:1],
                                 // current_slot[8:5], was_hit[9], rewind[10]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  lst_pkg::cfg_t                               cfg;
  lst_pkg::cell_cmd_t                          cmd;
  lst_pkg::entry_t [lst_pkg::SLOTS-1:0]        entries;
  logic [lst_pkg::SLOTS-1:0]                   match;
  logic                                        res_success;
  logic [3:0]                                  res_pos;
  logic [3:0]                                  res_slot;
  logic                                        res_hit;
  logic                                        res_rewind;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cycle_enable <= 1'b0;
      cfg.cycle_length <= 4'd8;
      cfg.auto_rewind  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lst_pkg::CFG_CYCLE_ENABLE: cfg.cycle_enable <= cfg_data[0];
        lst_pkg::CFG_CYCLE_LENGTH: cfg.cycle_length <= cfg_data;
        lst_pkg::CFG_AUTO_REWIND:  cfg.auto_rewind  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  lst_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .mode        (s_tuser),
    .key         (s_tdata[31:0]),
    .open_ok     (s_tdata[32]),
    .delta       ($signed(s_tdata[37:33])),
    .position    (s_tdata[41:38]),
    .entries     (entries),
    .match       (match),
    .cmd         (cmd),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .res_success (res_success),
    .res_pos     (res_pos),
    .res_slot    (res_slot),
    .res_hit     (res_hit),
    .res_rewind  (res_rewind)
  );

  // Row of cells, front of the list at cell 0. On a move to front every cell
  // up to the moved position takes its left neighbor's entry, and cell 0 takes
  // the entry that moves to the front.
  for (genvar i = 0; i < lst_pkg::SLOTS; i++) begin : g_cell
    lst_pkg::entry_t load_entry;
    logic            load;

    assign load       = cmd.shift && (lst_pkg::IDX_W'(i) <= cmd.upto);
    if (i == 0) begin : g_front
      assign load_entry = cmd.front;
    end else begin : g_link
      assign load_entry = entries[i-1];
    end

    lst_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .init_slot  (lst_pkg::IDX_W'(i)),
      .key        (cmd.key),
      .clear      (cmd.clear),
      .load       (load),
      .load_entry (load_entry),
      .entry      (entries[i]),
      .match      (match[i])
    );
  end

  assign m_tdata = {5'd0, res_rewind, res_hit, res_slot, res_pos, res_success};

endmodule
